// File: src/slcd_pkg.sv
// ============================================================================
// slcd_pkg - shared types and constants for the segmented length code decoder
// Item kinds, phases, queue status and the fixed field widths of the ports.
// ============================================================================
package slcd_pkg;

    // Defaults of the top-level parameters
    localparam int DICT_DEPTH_DEF  = 256;
    localparam int LENGTH_BITS_DEF = 3;

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int S_DATA_W = 16;   // dict_char + code_bit, padded to bytes
    localparam int S_USER_W = 2;    // action
    localparam int M_DATA_W = 8;    // char_out
    localparam int M_USER_W = 1;    // out_of_range

    // Depth of the queue between front and back (power of two)
    localparam int Q_DEPTH = 2;

    // Input item action codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_BIT   = 2'd2
    } t_action;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_LOAD   = 2'd0,
        PH_HEADER = 2'd1,
        PH_CODE   = 2'd2
    } t_phase;

    // Kind of a queued result
    typedef enum logic [1:0] {
        JOB_CHAR = 2'd0,
        JOB_EOM  = 2'd1,
        JOB_OOR  = 2'd2
    } t_job_kind;

    localparam int KIND_W = $bits(t_job_kind);

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/slcd_front.sv
// ============================================================================
// slcd_front - item intake and bit-level decode
// Tracks phase and counters, writes dictionary characters, queues results.
// ============================================================================
module slcd_front #(
    parameter int  DICT_DEPTH  = slcd_pkg::DICT_DEPTH_DEF,
    parameter int  LENGTH_BITS = slcd_pkg::LENGTH_BITS_DEF,
    localparam int AW          = $clog2(DICT_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  slcd_pkg::t_action         i_action,
    input  logic [slcd_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_bit,
    input  slcd_pkg::t_q_stat         i_q_stat,
    output logic                      o_push,
    output slcd_pkg::t_job_kind       o_kind,
    output logic [AW-1:0]             o_idx,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [slcd_pkg::CHAR_W-1:0] o_wdata
);
    import slcd_pkg::*;

    localparam int CW = $clog2(DICT_DEPTH + 1);
    localparam int VW = (1 << LENGTH_BITS) - 1;   // widest code
    localparam int IW = VW + 1;                   // index width
    localparam int HW = $clog2(LENGTH_BITS);
    localparam int XW = (IW > CW) ? IW : CW;

    t_phase                 r_phase, n_phase;
    logic [CW-1:0]          r_count, n_count;
    logic [HW-1:0]          r_hdr_cnt, n_hdr_cnt;
    logic [LENGTH_BITS-1:0] r_seg, n_seg;
    logic [LENGTH_BITS-1:0] r_code_cnt, n_code_cnt;
    logic [VW-1:0]          r_code_val, n_code_val;

    logic                   dict_open;
    logic                   write_hazard;
    logic                   accept;
    logic [HW-1:0]          hdr_base;
    logic [LENGTH_BITS-1:0] seg_base;
    logic [LENGTH_BITS-1:0] seg_shift;
    logic                   hdr_done;
    logic [VW-1:0]          val_shift;
    logic                   code_done;
    logic [IW-1:0]          ones_w;
    logic                   is_close;
    logic [IW-1:0]          idx_w;
    logic [XW-1:0]          idx_x;
    logic                   in_range;

    // A dictionary write must not land under a lookup still queued
    assign dict_open    = (r_phase == PH_LOAD) && (r_count < CW'(DICT_DEPTH));
    assign write_hazard = (i_action == ACT_CHAR) && dict_open && !i_q_stat.empty;
    assign o_ready      = !i_q_stat.full && !write_hazard;
    assign accept       = i_valid && o_ready;

    // Header path: a bit in load phase starts a fresh header
    assign hdr_base  = (r_phase == PH_LOAD) ? '0 : r_hdr_cnt;
    assign seg_base  = (r_phase == PH_LOAD) ? '0 : r_seg;
    assign seg_shift = {seg_base[LENGTH_BITS-2:0], i_bit};
    assign hdr_done  = (hdr_base == HW'(LENGTH_BITS - 1));

    // Code path
    assign val_shift = {r_code_val[VW-2:0], i_bit};
    assign code_done = (r_code_cnt == (r_seg - 1'b1));
    assign ones_w    = (IW'(1) << r_seg) - IW'(1);
    assign is_close  = ({1'b0, val_shift} == ones_w);
    assign idx_w     = (IW'(1) << r_seg) - IW'(r_seg) - IW'(1) + {1'b0, val_shift};
    assign idx_x     = XW'(idx_w);
    assign in_range  = (idx_x < XW'(r_count));

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_hdr_cnt  = r_hdr_cnt;
        n_seg      = r_seg;
        n_code_cnt = r_code_cnt;
        n_code_val = r_code_val;
        if (accept) begin
            case (i_action)
                ACT_START: begin
                    n_phase    = PH_LOAD;
                    n_count    = '0;
                    n_hdr_cnt  = '0;
                    n_seg      = '0;
                    n_code_cnt = '0;
                    n_code_val = '0;
                end
                ACT_CHAR: begin
                    if (dict_open) begin
                        n_count = r_count + 1'b1;
                    end
                end
                ACT_BIT: begin
                    if (r_phase == PH_CODE) begin
                        if (code_done) begin
                            n_code_cnt = '0;
                            n_code_val = '0;
                            if (is_close) begin
                                n_phase   = PH_HEADER;
                                n_hdr_cnt = '0;
                                n_seg     = '0;
                            end
                        end else begin
                            n_code_cnt = r_code_cnt + 1'b1;
                            n_code_val = val_shift;
                        end
                    end else begin
                        n_seg      = seg_shift;
                        n_code_cnt = '0;
                        n_code_val = '0;
                        if (hdr_done) begin
                            n_hdr_cnt = '0;
                            n_phase   = (seg_shift == '0) ? PH_LOAD : PH_CODE;
                        end else begin
                            n_hdr_cnt = hdr_base + 1'b1;
                            n_phase   = PH_HEADER;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_push  = 1'b0;
        o_kind  = JOB_CHAR;
        o_idx   = idx_x[AW-1:0];
        o_we    = accept && (i_action == ACT_CHAR) && dict_open;
        o_waddr = r_count[AW-1:0];
        o_wdata = i_char;
        if (accept && (i_action == ACT_BIT)) begin
            if (r_phase == PH_CODE) begin
                if (code_done && !is_close) begin
                    o_push = 1'b1;
                    o_kind = in_range ? JOB_CHAR : JOB_OOR;
                end
            end else if (hdr_done && (seg_shift == '0)) begin
                o_push = 1'b1;
                o_kind = JOB_EOM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LOAD;
            r_count    <= '0;
            r_hdr_cnt  <= '0;
            r_seg      <= '0;
            r_code_cnt <= '0;
            r_code_val <= '0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_hdr_cnt  <= n_hdr_cnt;
            r_seg      <= n_seg;
            r_code_cnt <= n_code_cnt;
            r_code_val <= n_code_val;
        end
    end

endmodule

// File: src/slcd_queue.sv
// ============================================================================
// slcd_queue - short result queue between front and back
// Registered FIFO; no fall-through.
// ============================================================================
module slcd_queue #(
    parameter int W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [W-1:0]      i_data,
    input  logic              i_pop,
    output logic [W-1:0]      o_data,
    output slcd_pkg::t_q_stat o_stat
);
    import slcd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]  r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == NW'(Q_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// File: src/slcd_back.sv
// ============================================================================
// slcd_back - dictionary store and result output register
// Pops queued results, reads the dictionary, holds the result for the sink.
// ============================================================================
module slcd_back #(
    parameter int  DICT_DEPTH = slcd_pkg::DICT_DEPTH_DEF,
    localparam int AW         = $clog2(DICT_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [slcd_pkg::CHAR_W-1:0] i_wdata,
    input  slcd_pkg::t_q_stat           i_q_stat,
    input  slcd_pkg::t_job_kind         i_kind,
    input  logic [AW-1:0]               i_idx,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [slcd_pkg::CHAR_W-1:0] o_char,
    output logic                        o_eom,
    output logic                        o_oor
);
    import slcd_pkg::*;

    logic [CHAR_W-1:0] mem [DICT_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;
    t_job_kind         r_kind;
    logic              r_valid;

    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_kind == JOB_CHAR)) begin
            r_rd_data <= mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = (r_kind == JOB_CHAR) ? r_rd_data : '0;
    assign o_eom   = (r_kind == JOB_EOM);
    assign o_oor   = (r_kind == JOB_OOR);

endmodule

// File: src/segmented_length_code_decoder.sv
// ============================================================================
// segmented_length_code_decoder - segmented variable-length code decoder
// Dictionary load plus bit-serial segment decode, one item per cycle when s_axis is not stalled.
// ============================================================================
// Usage:
//   s_axis carries input items: tuser is the action (start, dictionary
//   character, code bit), tdata holds the character and the code bit.
//   m_axis carries decoded characters: tdata is the character, tlast marks
//   end of message (zero length header), tuser flags an out-of-range index.
//   Throughput: one input item per cycle. The only stall on s_axis besides
//   a full result queue is a dictionary character to be written during
//   loading while any result is still queued; it waits until the queue has
//   drained into the output register, so no queued lookup can see the new write.
//   The code bit that completes a result writes it into the queue; the
//   back then pops it, reading the store into the output register that
//   drives m_axis.
//   When m_axis stalls, the output register holds its item and the
//   two-entry queue keeps absorbing results; code bits on s_axis stall only
//   once the queue is full.
//   Reset (i_rst_n low, synchronous) clears phase, counters, dictionary
//   count, queue and output valid. The dictionary store has no reset and
//   needs no clearing pass: only entries below the loaded count are read.
// ============================================================================
module segmented_length_code_decoder #(
    parameter int DICT_DEPTH  = slcd_pkg::DICT_DEPTH_DEF,
    parameter int LENGTH_BITS = slcd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [slcd_pkg::S_DATA_W-1:0] s_axis_tdata,   // [7:0] dict_char, [8] code_bit
    input  logic [slcd_pkg::S_USER_W-1:0] s_axis_tuser,   // [1:0] action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [slcd_pkg::M_DATA_W-1:0] m_axis_tdata,   // [7:0] char_out
    output logic                          m_axis_tlast,   // end_of_message
    output logic [slcd_pkg::M_USER_W-1:0] m_axis_tuser    // [0] out_of_range
);
    import slcd_pkg::*;

    localparam int AW = $clog2(DICT_DEPTH);
    localparam int JW = KIND_W + AW;   // queue entry: {kind, index}

    t_action           action;
    t_q_stat           q_stat;
    logic              push, pop;
    t_job_kind         f_kind, b_kind;
    logic [AW-1:0]     f_idx;
    logic [JW-1:0]     q_out;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CHAR_W-1:0] wdata;
    logic              oor;

    assign action = t_action'(s_axis_tuser);

    // Front: intake, phase tracking, dictionary writes
    slcd_front #(
        .DICT_DEPTH  (DICT_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (action),
        .i_char   (s_axis_tdata[CHAR_W-1:0]),
        .i_bit    (s_axis_tdata[CHAR_W]),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_kind   (f_kind),
        .o_idx    (f_idx),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata)
    );

    // Result queue decoupling front from back
    slcd_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_kind, f_idx}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    assign b_kind = t_job_kind'(q_out[JW-1:AW]);

    // Back: dictionary store, read, output register
    slcd_back #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_q_stat (q_stat),
        .i_kind   (b_kind),
        .i_idx    (q_out[AW-1:0]),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_char   (m_axis_tdata),
        .o_eom    (m_axis_tlast),
        .o_oor    (oor)
    );

    assign m_axis_tuser = oor;

endmodule

// File: src/slcd_checker.sv
// ============================================================================
// slcd_checker - port-level checks for the segmented length code decoder
// Output channel behavior over time; bound to the top level.
// ============================================================================
module slcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [slcd_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic [slcd_pkg::M_USER_W-1:0] m_axis_tuser
);
    import slcd_pkg::*;

    // A stalled item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    // End of message carries no character and no range flag
    a_eom_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == '0) && (m_axis_tuser == '0))
        else $error("end of message with nonzero payload");

    // Out-of-range result carries a zero character
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("out-of-range result with character or end flag");

    // Reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

endmodule

bind segmented_length_code_decoder slcd_checker u_slcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/segmented_length_code_decoder_test.sv
// ============================================================================
// segmented_length_code_decoder_test - self-checking testbench
// Drives dictionary loads and segmented code bit streams into the decoder and
// checks every decoded character, end-of-message and out-of-range flag
// against an in-bench decoder model. Both stream sides idle at random.
// ============================================================================
`timescale 1ns / 1ps

module segmented_length_code_decoder_test;
    import slcd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;   // ignored by the block
    localparam int IDLE_LIMIT   = 4000;         // cycles with no item moving
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_PRINTS   = 30;
    localparam int RANDOM_ITEMS = 1480;

    typedef struct {
        logic [7:0] ch;
        logic       eom;
        logic       oor;
    } dec_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;     // [7:0] dict_char, [8] code_bit
    logic [S_USER_W-1:0] s_axis_tuser = '0;     // [1:0] action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;          // [7:0] char_out
    logic                m_axis_tlast;          // end_of_message
    logic [M_USER_W-1:0] m_axis_tuser;          // [0] out_of_range

    segmented_length_code_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------------
    logic [7:0]  dict_mem [DICT_DEPTH_DEF];
    int          dict_cnt = 0;
    t_phase      dec_phase = PH_LOAD;
    int          hdr_seen = 0;
    logic [2:0]  seg_len = '0;
    int          code_seen = 0;
    logic [6:0]  code_val = '0;

    dec_result_t pending_chars [$];     // decoded results not yet seen

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  eom_seen = 0;
    int  oor_seen = 0;
    int  messages_sent = 0;
    int  idle_cycles = 0;
    int  hold_cycles = 0;               // long receiver hold-off, set by a test
    bit  tx_gaps_on = 1'b1;
    bit  rx_gaps_on = 1'b1;

    // Advances the model by one accepted item; returns 1 if the item had any
    // effect (ignored items do not count toward the stimulus budget).
    function automatic bit decode_item(logic [1:0] act, logic [7:0] ch, logic cbit);
        dec_result_t r;
        int          all_ones;
        int          idx;
        int          v;
        if (act == ACT_START) begin
            dict_cnt  = 0;
            dec_phase = PH_LOAD;
            hdr_seen  = 0;
            seg_len   = '0;
            code_seen = 0;
            code_val  = '0;
            return 1'b1;
        end
        if (act == ACT_CHAR) begin
            // chars are dropped once full, and ignored outside loading
            if (dec_phase == PH_LOAD && dict_cnt < DICT_DEPTH_DEF) begin
                dict_mem[dict_cnt] = ch;
                dict_cnt++;
                return 1'b1;
            end
            return 1'b0;
        end
        if (act != ACT_BIT)
            return 1'b0;

        // first code bit ends loading and opens a length header
        if (dec_phase == PH_LOAD) begin
            dec_phase = PH_HEADER;
            hdr_seen  = 0;
            seg_len   = '0;
            code_seen = 0;
            code_val  = '0;
        end

        if (dec_phase == PH_HEADER) begin
            seg_len = {seg_len[1:0], cbit};
            hdr_seen++;
            if (hdr_seen < LENGTH_BITS_DEF)
                return 1'b1;
            hdr_seen  = 0;
            code_seen = 0;
            code_val  = '0;
            if (seg_len == 3'd0) begin
                dec_phase = PH_LOAD;
                r = '{ch: 8'h00, eom: 1'b1, oor: 1'b0};
                pending_chars.push_back(r);
            end else begin
                dec_phase = PH_CODE;
            end
            return 1'b1;
        end

        code_val = {code_val[5:0], cbit};
        code_seen++;
        if (code_seen < int'(seg_len))
            return 1'b1;
        all_ones  = (1 << seg_len) - 1;
        v         = int'(code_val);
        code_seen = 0;
        code_val  = '0;
        if (v == all_ones) begin
            // segment close: back to a new length header, no result
            dec_phase = PH_HEADER;
            hdr_seen  = 0;
            seg_len   = '0;
            return 1'b1;
        end
        idx = (1 << seg_len) - int'(seg_len) - 1 + v;
        if (idx < dict_cnt)
            r = '{ch: dict_mem[idx], eom: 1'b0, oor: 1'b0};
        else
            r = '{ch: 8'h00, eom: 1'b0, oor: 1'b1};
        pending_chars.push_back(r);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    // One item on s_axis. Valid is left high after the accept so that a
    // following item can go out without a bubble.
    task automatic send_item(logic [1:0] act, logic [7:0] ch, logic cbit);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, cbit, ch};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (decode_item(act, ch, cbit))
            items_sent++;
    endtask

    // Code bits go out MSB first; the unused char field carries noise.
    task automatic send_bits(int value, int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            send_item(ACT_BIT, 8'($urandom), value[i]);
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Sender stops and waits for every outstanding result, then lets the
    // pipeline settle.
    task automatic drain_results();
        sender_idle();
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed message with random content; with noisy set, stray
    // items are sprinkled in and may break the sequence.
    task automatic send_message(bit with_start, int dict_len, int n_segments, bit noisy);
        int len;
        int n_codes;
        int r;
        if (with_start)
            send_item(ACT_START, 8'($urandom), 1'($urandom));
        for (int i = 0; i < dict_len; i++)
            send_item(ACT_CHAR, 8'($urandom), 1'($urandom));
        for (int s = 0; s < n_segments; s++) begin
            len = $urandom_range(1, 7);
            send_bits(len, LENGTH_BITS_DEF);
            n_codes = $urandom_range(0, 6);
            for (int c = 0; c < n_codes; c++) begin
                if (noisy && $urandom_range(0, 24) == 0) begin
                    r = $urandom_range(0, 3);
                    send_item(2'(r), 8'($urandom), 1'($urandom));
                end
                send_bits($urandom_range(0, (1 << len) - 2), len);
            end
            send_bits((1 << len) - 1, len);
        end
        send_bits(0, LENGTH_BITS_DEF);
        messages_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Short hand-built message: char extremes, each segment outcome, stray
    // and unused items, and an append after message end.
    task automatic test_directed();
        send_item(ACT_START, 8'h00, 1'b0);
        send_item(ACT_CHAR, 8'h00, 1'b0);
        send_item(ACT_CHAR, 8'hFF, 1'b1);
        send_item(ACT_CHAR, 8'h5A, 1'b0);
        send_bits(1, 3);                        // L = 1
        send_bits(0, 1);                        // index 0
        send_bits(1, 1);                        // close
        send_bits(2, 3);                        // L = 2
        send_bits(0, 2);                        // index 1
        send_item(ACT_CHAR, 8'hC3, 1'b1);       // ignored: not loading
        send_bits(2, 2);                        // index 3: out of range
        send_item(ACT_UNUSED, 8'hFF, 1'b1);     // ignored
        send_bits(3, 2);                        // close
        send_bits(0, 3);                        // message end
        send_item(ACT_CHAR, 8'hA5, 1'b1);       // appends at index 3
        send_bits(2, 3);
        send_bits(2, 2);                        // index 3 now in range
        drain_results();
    endtask

    // Fill the whole store, overrun it, then read the entries at the edges
    // of the two longest code lengths.
    task automatic test_dict_full();
        send_item(ACT_START, 8'h00, 1'b0);
        for (int i = 0; i < DICT_DEPTH_DEF + 3; i++)
            send_item(ACT_CHAR, 8'($urandom), 1'($urandom));
        send_bits(7, 3);
        send_bits(0, 7);                        // index 120
        send_bits(126, 7);                      // index 246
        send_bits(127, 7);
        send_bits(6, 3);
        send_bits(62, 6);                       // index 119
        send_bits(63, 6);
        send_bits(0, 3);
        drain_results();
    endtask

    // Receiver holds off while a run of one-bit codes keeps producing
    // results, so the output side fills and s_axis stalls.
    task automatic test_backpressure();
        bit saved_gaps;
        saved_gaps = tx_gaps_on;
        tx_gaps_on = 1'b0;
        @(posedge i_clk);
        hold_cycles = 200;
        send_item(ACT_START, 8'h00, 1'b0);
        send_item(ACT_CHAR, 8'($urandom), 1'b0);
        send_item(ACT_CHAR, 8'($urandom), 1'b0);
        send_bits(1, 3);
        for (int i = 0; i < 40; i++)
            send_bits(0, 1);
        send_bits(1, 1);
        send_bits(0, 3);
        drain_results();
        tx_gaps_on = saved_gaps;
    endtask

    task automatic test_random_messages();
        int stop_at;
        int dict_len;
        int next_switch;
        stop_at     = items_sent + RANDOM_ITEMS;
        next_switch = items_sent;
        while (items_sent < stop_at) begin
            // now and then change idling so stretches run without gaps
            if (items_sent >= next_switch) begin
                tx_gaps_on  = $urandom_range(0, 2) != 0;
                rx_gaps_on  = $urandom_range(0, 2) != 0;
                next_switch = items_sent + 150;
            end
            if ($urandom_range(0, 7) == 0)
                dict_len = $urandom_range(60, 130);
            else
                dict_len = $urandom_range(0, 40);
            send_message($urandom_range(0, 5) != 0, dict_len,
                         $urandom_range(1, 5), $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus the long hold-off requested by a test
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_gaps_on)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: oldest expectation against each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        dec_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_chars.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 0);
            end else begin
                want = pending_chars.pop_front();
                if (want.eom)
                    eom_seen++;
                if (want.oor)
                    oor_seen++;
                if (m_axis_tdata !== want.ch)
                    report_mismatch("char_out", m_axis_tdata, want.ch);
                if (m_axis_tlast !== want.eom)
                    report_mismatch("end_of_message", m_axis_tlast, want.eom);
                if (m_axis_tuser[0] !== want.oor)
                    report_mismatch("out_of_range", m_axis_tuser[0], want.oor);
            end
        end
    end

    // Watchdog: any stretch with no item moving on either side is a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_dict_full();
        test_backpressure();
        test_random_messages();
        drain_results();
        $display("run: %0d items, %0d messages, %0d results checked",
                 items_sent, messages_sent, results_seen);
        $display("run: %0d message ends, %0d out-of-range lookups, %0d mismatches",
                 eom_seen, oor_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
